// File: rtl/drmt_pkg.sv
package drmt_pkg;
  localparam logic [2:0] ST_IGNORED = 3'd0;
  localparam logic [2:0] ST_COUNTED = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_ENTRY   = 3'd3;
  localparam logic [2:0] ST_EMPTY   = 3'd4;
  localparam logic [2:0] ST_CLEARED = 3'd5;

  localparam logic [1:0] FN_FRAME  = 2'd0;
  localparam logic [1:0] FN_REPORT = 2'd1;
  localparam logic [1:0] FN_CLEAR  = 2'd2;
  localparam logic [1:0] FN_UNUSED = 2'd3;

  localparam logic [1:0] REG_WINDOW = 2'd0;
  localparam logic [1:0] REG_FLOOD  = 2'd1;
  localparam logic [1:0] REG_BURST  = 2'd2;

  localparam logic [1:0]  TYPE_MGMT    = 2'd0;

  localparam logic [15:0] WINDOW_RESET = 16'd1000;
  localparam logic [15:0] FLOOD_RESET  = 16'd10;
  localparam logic [15:0] BURST_RESET  = 16'd5;
  localparam logic [11:0] MIN_LENGTH   = 12'd22;
  localparam logic [3:0]  SUB_DEAUTH   = 4'd12;
  localparam logic [3:0]  SUB_DISASSOC = 4'd10;
  localparam logic [9:0]  RATE_SCALE   = 10'd1000;

  typedef struct packed {
    logic [47:0] bssid;
    logic [15:0] count;
    logic [15:0] peak;
    logic [31:0] wstart;
  } slot_t;
endpackage

// File: rtl/drmt_ram.sv
module drmt_ram #(
  parameter int WIDTH = 112,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/drmt_div.sv
module drmt_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [25:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [25:0] quotient
);
  import drmt_pkg::*;

  logic [25:0] q_r, q_nxt;
  logic [16:0] rem_r, rem_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        run_r, run_nxt;
  logic        done_r, done_nxt;
  logic [16:0] trial;

  // restoring division, one quotient bit per cycle
  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    trial    = {rem_r[15:0], q_r[25]};
    if (go) begin
      q_nxt   = dividend;
      rem_nxt = 17'd0;
      cnt_nxt = 5'd0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = trial - {1'b0, divisor};
        q_nxt   = {q_r[24:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[24:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd25) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 5'd0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;
endmodule

// File: rtl/deauth_rate_monitor_table_unit.sv
// Deauth/disassoc rate monitor table.
// Input channel: drive in_func and the frame fields with start high; the
// transaction is taken at an edge where start is high and busy is low. busy
// drops in the cycle in which the last result of that transaction is shown.
// Result channel: each result sits on the out_ ports for one cycle with
// out_valid high; out_last_result marks the final one. The receiver cannot
// stall, so results go out as soon as they are ready.
// Frame transaction: the table is searched through the RAM read port slot by
// slot, each slot in a read state and then a compare state, then an update
// state. A report walks the used entries one at a time, each through RAM read,
// 16x10 multiply, divider load, the bit-serial rate divider (26 steps plus
// done) and the emit state. Clear, empty report, ignored frames and unknown
// codes show their result in the cycle after acceptance and never raise
// busy.
// Configuration: APB port, window_ms at 0x0, flood_rate_limit at 0x4,
// burst_minimum at 0x8; pready is always high. Write only while idle.
// Reset (synchronous, rst_n low) empties the table and reloads the register
// defaults; slot contents are left as they are and are never read unwritten.
module deauth_rate_monitor_table_unit #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_func,
  input  logic [15:0] in_frame_control,
  input  logic [11:0] in_frame_length,
  input  logic [47:0] in_frame_bssid,
  input  logic [31:0] in_now_ms,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [5:0]  out_entry_index,
  output logic [47:0] out_entry_bssid,
  output logic [15:0] out_window_count,
  output logic [15:0] out_peak_count,
  output logic [25:0] out_frame_rate,
  output logic        out_flood_flag,
  output logic        out_harvest_flag,
  output logic        out_last_result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import drmt_pkg::*;

  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_ENTRIES);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SCAN  = 4'd1;
  localparam logic [3:0] S_CMP   = 4'd2;
  localparam logic [3:0] S_UPD   = 4'd3;
  localparam logic [3:0] S_RRD   = 4'd4;
  localparam logic [3:0] S_RMUL  = 4'd5;
  localparam logic [3:0] S_RDIV  = 4'd6;
  localparam logic [3:0] S_RWAIT = 4'd7;
  localparam logic [3:0] S_EMIT  = 4'd8;

  logic [3:0]    state_r, state_nxt;
  logic [CW-1:0] used_r, used_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [15:0]   window_r, flood_r, burst_r;
  logic [47:0]   bssid_r;
  logic [31:0]   now_r;
  logic          hit_r, hit_nxt;

  // result register
  logic        ov_r, ov_nxt;
  logic [2:0]  os_r, os_nxt;
  logic [5:0]  oi_r, oi_nxt;
  logic [47:0] ob_r, ob_nxt;
  logic [15:0] oc_r, oc_nxt, op_r, op_nxt;
  logic [25:0] orate_r, orate_nxt;
  logic        of_r, of_nxt, oh_r, oh_nxt, ol_r, ol_nxt;

  logic [25:0] prod_r, prod_nxt;
  slot_t       rd, wr;
  logic        we;
  logic [AW-1:0] raddr, waddr;
  logic        div_go, div_done;
  logic [25:0] quot;
  logic [15:0] divisor;

  logic        accept, cfg_wr, relevant;
  logic [31:0] elapsed;
  logic [15:0] cnt_tmp;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;
  assign relevant = (in_frame_control[3:2] == TYPE_MGMT) &&
                    ((in_frame_control[7:4] == SUB_DEAUTH) ||
                     (in_frame_control[7:4] == SUB_DISASSOC)) &&
                    (in_frame_length >= MIN_LENGTH);
  assign divisor = (window_r == 16'd0) ? 16'd1 : window_r;

  always_comb begin
    case (paddr[3:2])
      REG_WINDOW: prdata = {16'd0, window_r};
      REG_FLOOD:  prdata = {16'd0, flood_r};
      REG_BURST:  prdata = {16'd0, burst_r};
      default:    prdata = 32'd0;
    endcase
  end

  drmt_ram #(.WIDTH($bits(slot_t)), .DEPTH(TABLE_ENTRIES)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wr),
    .raddr(raddr), .rdata(rd)
  );

  drmt_div u_div (
    .clk(clk), .rst_n(rst_n), .go(div_go), .dividend(prod_r),
    .divisor(divisor), .done(div_done), .quotient(quot)
  );

  always_comb begin
    state_nxt = state_r;
    used_nxt  = used_r;
    idx_nxt   = idx_r;
    hit_nxt   = hit_r;
    prod_nxt  = prod_r;
    ov_nxt = 1'b0; os_nxt = os_r; oi_nxt = oi_r; ob_nxt = ob_r;
    oc_nxt = oc_r; op_nxt = op_r; orate_nxt = orate_r;
    of_nxt = of_r; oh_nxt = oh_r; ol_nxt = ol_r;
    we     = 1'b0;
    waddr  = idx_r[AW-1:0];
    wr     = rd;
    raddr  = idx_r[AW-1:0];
    div_go = 1'b0;
    elapsed = now_r - rd.wstart;
    cnt_tmp = 16'd0;
    case (state_r)
      S_IDLE: begin
        raddr = '0;
        if (accept) begin
          idx_nxt = '0;
          hit_nxt = 1'b0;
          os_nxt = ST_IGNORED; oi_nxt = 6'd0; ob_nxt = 48'd0; oc_nxt = 16'd0;
          op_nxt = 16'd0; orate_nxt = 26'd0; of_nxt = 1'b0; oh_nxt = 1'b0;
          ol_nxt = 1'b1;
          case (in_func)
            FN_FRAME: begin
              if (!relevant) begin
                ov_nxt = 1'b1;
              end else if (used_r == '0) begin
                state_nxt = S_UPD;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            FN_REPORT: begin
              if (used_r == '0) begin
                ov_nxt = 1'b1;
                os_nxt = ST_EMPTY;
              end else begin
                state_nxt = S_RRD;
              end
            end
            FN_CLEAR: begin
              used_nxt = '0;
              ov_nxt   = 1'b1;
              os_nxt   = ST_CLEARED;
            end
            default: ov_nxt = 1'b1;
          endcase
        end
      end
      S_SCAN: state_nxt = S_CMP; // read of slot idx in flight
      S_CMP: begin
        if (rd.bssid == bssid_r) begin
          hit_nxt   = 1'b1;
          state_nxt = S_UPD;
        end else if (idx_r + CW'(1) >= used_r) begin
          idx_nxt   = used_r;
          state_nxt = S_UPD;
        end else begin
          idx_nxt   = idx_r + CW'(1);
          raddr     = idx_nxt[AW-1:0];
          state_nxt = S_SCAN;
        end
      end
      S_UPD: begin
        if (!hit_r && used_r >= FULL_COUNT) begin
          ov_nxt = 1'b1; os_nxt = ST_FULL; ob_nxt = bssid_r;
        end else begin
          wr = rd;
          if (!hit_r) begin
            wr.bssid = bssid_r; wr.count = 16'd0; wr.peak = 16'd0;
            wr.wstart = now_r;
            used_nxt = used_r + CW'(1);
          end
          elapsed = now_r - wr.wstart;
          if (elapsed > {16'd0, window_r}) begin
            wr.count = 16'd0; wr.wstart = now_r;
          end
          cnt_tmp = (wr.count == 16'hFFFF) ? wr.count : wr.count + 16'd1;
          wr.count = cnt_tmp;
          if (cnt_tmp > wr.peak) wr.peak = cnt_tmp;
          we = 1'b1;
          ov_nxt = 1'b1; os_nxt = ST_COUNTED; oi_nxt = 6'(idx_r);
          ob_nxt = wr.bssid; oc_nxt = wr.count; op_nxt = wr.peak;
        end
        state_nxt = S_IDLE;
      end
      S_RRD: state_nxt = S_RMUL;
      S_RMUL: begin
        prod_nxt  = 26'(rd.count) * 26'(RATE_SCALE);
        state_nxt = S_RDIV;
      end
      S_RDIV: begin
        div_go    = 1'b1;
        state_nxt = S_RWAIT;
      end
      S_RWAIT: begin
        if (div_done) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        ov_nxt = 1'b1; os_nxt = ST_ENTRY; oi_nxt = 6'(idx_r);
        ob_nxt = rd.bssid; oc_nxt = rd.count; op_nxt = rd.peak;
        orate_nxt = quot;
        of_nxt = (quot >= 26'(flood_r));
        oh_nxt = !(quot >= 26'(flood_r)) && (rd.peak >= burst_r);
        ol_nxt = (idx_r + CW'(1) >= used_r);
        if (idx_r + CW'(1) >= used_r) begin
          state_nxt = S_IDLE;
        end else begin
          idx_nxt   = idx_r + CW'(1);
          raddr     = idx_nxt[AW-1:0];
          state_nxt = S_RRD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      used_r   <= '0;
      idx_r    <= '0;
      hit_r    <= 1'b0;
      ov_r     <= 1'b0;
      window_r <= WINDOW_RESET;
      flood_r  <= FLOOD_RESET;
      burst_r  <= BURST_RESET;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
      idx_r   <= idx_nxt;
      hit_r   <= hit_nxt;
      ov_r    <= ov_nxt;
      if (cfg_wr) begin
        case (paddr[3:2])
          REG_WINDOW: window_r <= pwdata[15:0];
          REG_FLOOD:  flood_r  <= pwdata[15:0];
          REG_BURST:  burst_r  <= pwdata[15:0];
          default: ;
        endcase
      end
    end
    if (accept) begin
      bssid_r <= in_frame_bssid;
      now_r   <= in_now_ms;
    end
    prod_r <= prod_nxt;
    os_r <= os_nxt; oi_r <= oi_nxt; ob_r <= ob_nxt; oc_r <= oc_nxt;
    op_r <= op_nxt; orate_r <= orate_nxt; of_r <= of_nxt; oh_r <= oh_nxt;
    ol_r <= ol_nxt;
  end

  assign out_valid        = ov_r;
  assign out_status       = os_r;
  assign out_entry_index  = oi_r;
  assign out_entry_bssid  = ob_r;
  assign out_window_count = oc_r;
  assign out_peak_count   = op_r;
  assign out_frame_rate   = orate_r;
  assign out_flood_flag   = of_r;
  assign out_harvest_flag = oh_r;
  assign out_last_result  = ol_r;

`ifndef NO_ASSERTIONS
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= FULL_COUNT) else $error("entry count past table size");
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_flood_flag && out_harvest_flag))
    else $error("flood and harvest both set");
  a_idle_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_result) |-> !busy)
    else $error("last result while still busy");
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP) |-> (idx_r < used_r))
    else $error("scan index past used entries");
`endif
endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
  import drmt_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_func = '0;
  logic [15:0] in_frame_control = '0;
  logic [11:0] in_frame_length = '0;
  logic [47:0] in_frame_bssid = '0;
  logic [31:0] in_now_ms = '0;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [5:0]  out_entry_index;
  logic [47:0] out_entry_bssid;
  logic [15:0] out_window_count;
  logic [15:0] out_peak_count;
  logic [25:0] out_frame_rate;
  logic        out_flood_flag;
  logic        out_harvest_flag;
  logic        out_last_result;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  deauth_rate_monitor_table_unit dut (.*);

  always #10 clk = ~clk;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  index;
    logic [47:0] bssid;
    logic [15:0] count;
    logic [15:0] peak;
    logic [25:0] rate;
    logic        flood;
    logic        harvest;
    logic        last;
  } verdict_t;

  // Predicted table and registers
  logic [15:0] win_len, flood_lim, burst_min;
  int unsigned used_slots;
  logic [47:0] tbl_bssid [64];
  logic [15:0] tbl_count [64];
  logic [15:0] tbl_peak [64];
  logic [31:0] tbl_start [64];

  verdict_t pending_verdicts [$];
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned items_sent = 0;
  int unsigned idle_pct = 0;
  int unsigned quiet_cycles = 0;
  logic [47:0] bssid_pool [8];

  function automatic verdict_t blank(logic [2:0] st);
    verdict_t v;
    v = '0;
    v.status = st;
    v.last = 1'b1;
    return v;
  endfunction

  // Append one predicted result to the tail of the queue
  function automatic void queue_verdict(verdict_t v);
    pending_verdicts = {pending_verdicts, v};
  endfunction

  // Compute the results of one transaction and advance the predicted table
  task automatic predict_table(input logic [1:0] fn, input logic [15:0] fc,
                               input logic [11:0] len, input logic [47:0] bs,
                               input logic [31:0] now);
    verdict_t v;
    int unsigned i;
    logic [31:0] rate, dv;
    if (fn == FN_FRAME) begin
      if (fc[3:2] != TYPE_MGMT || (fc[7:4] != SUB_DEAUTH && fc[7:4] != SUB_DISASSOC) ||
          len < MIN_LENGTH) begin
        queue_verdict(blank(ST_IGNORED));
        return;
      end
      for (i = 0; i < used_slots; i++) if (tbl_bssid[i] == bs) break;
      if (i >= used_slots) begin
        if (used_slots >= 64) begin
          v = blank(ST_FULL);
          v.bssid = bs;
          queue_verdict(v);
          return;
        end
        i = used_slots;
        tbl_bssid[i] = bs;
        tbl_count[i] = '0;
        tbl_peak[i] = '0;
        tbl_start[i] = now;
        used_slots++;
      end
      if (now - tbl_start[i] > {16'd0, win_len}) begin
        tbl_count[i] = '0;
        tbl_start[i] = now;
      end
      if (tbl_count[i] != 16'hFFFF) tbl_count[i]++;
      if (tbl_count[i] > tbl_peak[i]) tbl_peak[i] = tbl_count[i];
      v = blank(ST_COUNTED);
      v.index = i[5:0];
      v.bssid = tbl_bssid[i];
      v.count = tbl_count[i];
      v.peak = tbl_peak[i];
      queue_verdict(v);
    end else if (fn == FN_REPORT) begin
      if (used_slots == 0) begin
        queue_verdict(blank(ST_EMPTY));
        return;
      end
      dv = (win_len == 0) ? 32'd1 : {16'd0, win_len};
      for (i = 0; i < used_slots; i++) begin
        rate = {16'd0, tbl_count[i]} * 32'd1000 / dv;
        v = blank(ST_ENTRY);
        v.index = i[5:0];
        v.bssid = tbl_bssid[i];
        v.count = tbl_count[i];
        v.peak = tbl_peak[i];
        v.rate = rate[25:0];
        v.flood = rate >= {16'd0, flood_lim};
        v.harvest = !v.flood && tbl_peak[i] >= burst_min;
        v.last = (i + 1 == used_slots);
        queue_verdict(v);
      end
    end else if (fn == FN_CLEAR) begin
      used_slots = 0;
      queue_verdict(blank(ST_CLEARED));
    end else begin
      queue_verdict(blank(ST_IGNORED));
    end
  endtask

  // Send one transaction; hold start until busy is low at an edge.
  // start stays high after acceptance; the next idle cycle or drain drops it.
  task automatic send_item(input logic [1:0] fn, input logic [15:0] fc,
                           input logic [11:0] len, input logic [47:0] bs,
                           input logic [31:0] now);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_func <= fn;
    in_frame_control <= fc;
    in_frame_length <= len;
    in_frame_bssid <= bs;
    in_now_ms <= now;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_table(fn, fc, len, bs, now);
    items_sent++;
  endtask

  task automatic wait_drain();
    start <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= {16'($urandom()), val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_WINDOW: win_len = val;
      REG_FLOOD:  flood_lim = val;
      default:    burst_min = val;
    endcase
  endtask

  task automatic set_regs(input logic [15:0] w, input logic [15:0] f,
                          input logic [15:0] b);
    wait_drain();
    write_reg(REG_WINDOW, w);
    write_reg(REG_FLOOD, f);
    write_reg(REG_BURST, b);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic logic [15:0] good_fc();
    logic [15:0] fc;
    fc = 16'($urandom());
    fc[3:2] = TYPE_MGMT;
    fc[7:4] = $urandom_range(1) ? SUB_DEAUTH : SUB_DISASSOC;
    return fc;
  endfunction

  // Compare every strobed result against the oldest prediction
  always @(posedge clk) begin
    verdict_t got, want;
    if (rst_n && out_valid) begin
      got = {out_status, out_entry_index, out_entry_bssid, out_window_count,
             out_peak_count, out_frame_rate, out_flood_flag, out_harvest_flag,
             out_last_result};
      results_seen++;
      if (pending_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = pending_verdicts.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h actual %h", want, got);
        end
      end
    end
  end

  // Watchdog: count cycles where nothing moves
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || psel) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic test_directed();
    logic [31:0] t;
    t = 32'hFFFF_FF00;
    send_item(FN_REPORT, 0, 0, 0, 0);
    send_item(FN_FRAME, 16'h00C0, 12'd22, 48'hFFFF_FFFF_FFFF, t);
    send_item(FN_FRAME, 16'h00A0, 12'd4095, 48'h0, t + 5);
    send_item(FN_FRAME, 16'h00C0, 12'd21, 48'h1, t);
    send_item(FN_FRAME, 16'h00C4, 12'd100, 48'h1, t);
    send_item(FN_FRAME, 16'h00B0, 12'd100, 48'h1, t);
    send_item(FN_FRAME, 16'hFF3C, 12'd100, 48'h1, t);
    send_item(FN_FRAME, 16'hFF03 | 16'h00C0, 12'd30, 48'hFFFF_FFFF_FFFF, t + 10);
    // wrap past zero, then beyond the window
    send_item(FN_FRAME, 16'h00C0, 12'd30, 48'hFFFF_FFFF_FFFF, 32'd100);
    send_item(FN_FRAME, 16'h00C0, 12'd30, 48'hFFFF_FFFF_FFFF, 32'd2000);
    send_item(FN_UNUSED, 16'hFFFF, 12'hFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    send_item(FN_REPORT, 0, 0, 0, 0);
    send_item(FN_CLEAR, 0, 0, 0, 0);
    send_item(FN_REPORT, 0, 0, 0, 0);
  endtask

  // Fill every slot, overflow once, report the full table
  task automatic test_table_full();
    for (int i = 0; i < 65; i++)
      send_item(FN_FRAME, good_fc(), 12'd22 + 12'($urandom_range(200)),
                48'({$urandom(), $urandom()}), $urandom());
    send_item(FN_REPORT, 0, 0, 0, 0);
    send_item(FN_CLEAR, 0, 0, 0, 0);
  endtask

  task automatic test_random(input int n);
    logic [1:0] fn;
    logic [15:0] fc;
    logic [11:0] len;
    logic [47:0] bs;
    logic [31:0] now;
    for (int i = 0; i < n; i++) begin
      now = in_now_ms + $urandom_range(win_len > 0 ? {16'd0, win_len} : 32'd3);
      if ($urandom_range(9) == 0) now = $urandom();
      fn = FN_FRAME;
      fc = good_fc();
      len = 12'($urandom_range(4095, 22));
      bs = bssid_pool[$urandom_range(7)];
      case ($urandom_range(19))
        0: fn = FN_REPORT;
        1: fn = ($urandom_range(3) == 0) ? FN_CLEAR : FN_UNUSED;
        2: fc = 16'($urandom());
        3: len = 12'($urandom_range(21));
        4: bs = 48'({$urandom(), $urandom()});
        default: ;
      endcase
      send_item(fn, fc, len, bs, now);
    end
    send_item(FN_REPORT, 0, 0, 0, 0);
  endtask

  initial begin
    win_len = WINDOW_RESET;
    flood_lim = FLOOD_RESET;
    burst_min = BURST_RESET;
    used_slots = 0;
    foreach (bssid_pool[k]) bssid_pool[k] = 48'({$urandom(), $urandom()});
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_table_full();
    // zero window and low limits
    set_regs(16'd0, 16'd0, 16'd0);
    test_random(60);
    idle_pct = 80;
    set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF);
    test_random(80);
    // pause until every result is in
    wait_drain();
    idle_pct = 16;
    set_regs(16'd1, 16'd100, 16'd2);
    test_random(100);
    idle_pct = 0;
    set_regs(16'd50, 16'd40, 16'd3);
    test_random(120);
    idle_pct = 80;
    set_regs(WINDOW_RESET, FLOOD_RESET, BURST_RESET);
    test_random(60);
    wait_drain();
    $display("Sent %0d transactions, checked %0d results over five register sets,",
             items_sent, results_seen);
    $display("including full table, wrap, zero window and unknown codes.");
    if (mismatches == 0 && pending_verdicts.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

// File: files.f
rtl/drmt_pkg.sv
rtl/drmt_ram.sv
rtl/drmt_div.sv
rtl/deauth_rate_monitor_table_unit.sv
tb/tb_top.sv
